// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/hcd_pkg.sv
// Types, constants and helper functions of the chunked body decoder.
`default_nettype none

package hcd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_BODY = 2'd1,
        PH_SKIP = 2'd2
    } hcd_phase_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } hcd_status_t;

    typedef struct packed {
        logic advance;
        logic chunked_mode;
    } hcd_ctrl_t;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        chunk_end;
        hcd_status_t stream_status;
    } hcd_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hcd_hex_t;

    // Decodes one ASCII hex digit; ok is low for any other byte.
    function automatic hcd_hex_t hex_decode(input logic [7:0] c);
        hcd_hex_t r;
        r.ok    = 1'b1;
        r.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r.value = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            r.value = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            r.value = 4'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hcd_core.sv
// Decoder state registers and the per-byte next-state and result logic.
`default_nettype none

module hcd_core #(
    parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEFAULT
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire hcd_pkg::hcd_ctrl_t ctrl,
    input  wire  [7:0]           data_byte,
    output hcd_pkg::hcd_result_t result
);
    import hcd_pkg::*;

    hcd_phase_t           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] remaining_reg, remaining_next;
    hcd_status_t          status_reg, status_next;
    hcd_hex_t             hex;

    assign hex = hex_decode(data_byte);

    always_comb begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        status_next       = status_reg;
        result.body_valid = 1'b0;
        result.body_byte  = 8'd0;
        result.chunk_end  = 1'b0;

        if (status_reg == ST_RUN) begin
            if (!ctrl.chunked_mode) begin
                result.body_valid = 1'b1;
                result.body_byte  = data_byte;
            end else begin
                case (phase_reg)
                    PH_BODY: begin
                        result.body_valid = 1'b1;
                        result.body_byte  = data_byte;
                        if (remaining_reg[SIZE_BITS-1:1] == '0) begin
                            remaining_next   = '0;
                            result.chunk_end = 1'b1;
                            phase_next       = PH_SKIP;
                        end else begin
                            remaining_next = remaining_reg - 1'b1;
                        end
                    end
                    PH_SKIP: begin
                        if (data_byte == CHAR_LF) begin
                            remaining_next = '0;
                            phase_next     = PH_SIZE;
                        end
                    end
                    default: begin
                        if (data_byte == CHAR_CR) begin
                            phase_next = phase_reg;
                        end else if (data_byte == CHAR_LF) begin
                            if (remaining_reg != '0) begin
                                phase_next = PH_BODY;
                            end else begin
                                status_next = ST_DONE;
                            end
                        end else if (!hex.ok
                                     || remaining_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                            // A digit that would shift a nonzero nibble out is an overflow.
                            status_next = ST_ERR;
                        end else begin
                            remaining_next = {remaining_reg[SIZE_BITS-5:0], hex.value};
                        end
                    end
                endcase
            end
        end
        result.stream_status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SIZE;
            remaining_reg <= '0;
            status_reg    <= ST_RUN;
        end else if (ctrl.advance) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            status_reg    <= status_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/http_chunked_body_decoder.sv
// HTTP chunked transfer body decoder: top level with stream ports and output register.
//
// Accepts one body byte per clock and returns exactly one result transaction per
// byte, in the cycle after the byte is accepted, from an output register. The decode of a byte (hex size
// accumulation, chunk countdown, skip to end of line) finishes in the cycle the
// byte is accepted, so throughput is one byte per cycle; s_tready drops only while
// the output register holds a result that m_tready has not yet taken. m_tlast
// marks the last payload byte of a chunk. m_tuser bit 0 says whether m_tdata holds
// payload, and bits 2:1 give the stream status (0 running, 1 last chunk seen,
// 2 format error), which is sticky until reset. cfg_we writes chunked_mode and
// should be used only while the block is idle.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = hcd_pkg::SIZE_BITS_DEFAULT
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire        cfg_wdata,    // chunked_mode
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,      // data_byte
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,      // body_byte
    output logic       m_tlast,      // chunk_end
    output logic [2:0] m_tuser       // body_valid, stream_status[1:0]
);
    import hcd_pkg::*;

    logic        chunked_mode_reg;
    logic        m_valid_reg;
    hcd_result_t out_reg;
    hcd_ctrl_t   ctrl;
    hcd_result_t result;

    assign s_tready          = !m_valid_reg || m_tready;
    assign ctrl.advance      = s_tvalid && s_tready;
    assign ctrl.chunked_mode = chunked_mode_reg;

    hcd_core #(
        .SIZE_BITS(SIZE_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .data_byte (s_tdata),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunked_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            chunked_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.body_byte;
    assign m_tlast  = out_reg.chunk_end;
    assign m_tuser  = {out_reg.stream_status, out_reg.body_valid};

endmodule

`default_nettype wire

// File: rtl/hcd_checker.sv
// Port-level checker for the chunked body decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hcd_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire       m_tlast,
    input wire [2:0] m_tuser
);
    logic [1:0] last_status_reg;

    // Status of the most recent result that was taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_status_reg <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            last_status_reg <= m_tuser[2:1];
        end
    end

    `ASSERT_SAME(a_last_is_payload, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])
    `ASSERT_SAME(a_idle_byte_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 8'd0)
    `ASSERT_SAME(a_final_no_payload, aclk, aresetn, m_tvalid && m_tuser[2:1] != 2'd0, !m_tuser[0])
    `ASSERT_SAME(a_status_sticky, aclk, aresetn, m_tvalid && last_status_reg != 2'd0, m_tuser[2:1] == last_status_reg)
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

endmodule

bind http_chunked_body_decoder hcd_checker u_hcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
